[design/bpe_pkg.sv]
package bpe_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int T_FRAC_BITS = 16;
    localparam int COORD_FRAC  = 16;

    localparam int PIX_W    = 11;
    localparam int IDX_IN_W = 4;
    localparam int NP_W     = 5;
    localparam int T_W      = T_FRAC_BITS + 1;

    // Q11.16 working coordinate, difference, and t * difference product
    localparam int WORK_W = PIX_W + COORD_FRAC;
    localparam int DIFF_W = WORK_W + 1;
    localparam int PROD_W = DIFF_W + T_W + 1;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > NP_W) ? CNT_W : NP_W;

    localparam int T_HALF = 2 ** (T_FRAC_BITS - 1);
    localparam int C_HALF = 2 ** (COORD_FRAC - 1);

    localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Q11.16 to whole pixel, round half up
    function automatic logic [PIX_W-1:0] round_pix(input logic [WORK_W-1:0] v);
        logic [WORK_W:0] s;
        s = {1'b0, v} + (WORK_W + 1)'(C_HALF);
        return s[COORD_FRAC +: PIX_W];
    endfunction

endpackage

[design/bezier_point_evaluator_core.sv]
// Bezier curve point evaluator, de Casteljau scheme in Q11.16 fixed point.
// Request channel: start with func/point_index/point_x/point_y/t_value is
// taken on a rising edge where start is high and busy is low.
//   func write: stores one control point; busy stays low
//   and no result follows.
//   func evaluate: runs the curve over the first num_points table entries.
// Result channel: done pulses for one cycle with curve_x/curve_y valid. The
// receiver cannot stall; the result must be taken in that cycle.
// Config: cfg_we/cfg_data write num_points (0 acts as 1, above the table
// size acts as the table size); write only while the block is idle.
// Sequencing: an evaluation walks the levels on the shared lerp unit (x and
// y lanes side by side), one element read per cycle: N(N-1)/2 interpolations
// for N points plus one operand-priming read per level, then the DRAIN and
// FINISH states before done. A single point goes straight to FINISH. busy is
// high throughout.
// Reset clears the sequencer and sets num_points to 1; the point table is
// not cleared and must be written before it is evaluated.
module bezier_point_evaluator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [bpe_pkg::IDX_IN_W-1:0]  point_index,
    input  logic [bpe_pkg::PIX_W-1:0]     point_x,
    input  logic [bpe_pkg::PIX_W-1:0]     point_y,
    input  logic [bpe_pkg::T_W-1:0]       t_value,
    output logic                          done,
    output logic [bpe_pkg::PIX_W-1:0]     curve_x,
    output logic [bpe_pkg::PIX_W-1:0]     curve_y,
    input  logic                          cfg_we,
    input  logic [bpe_pkg::NP_W-1:0]      cfg_data
);
    import bpe_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] level_reg, level_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             first_reg, first_next;
    logic             single_reg, single_next;
    logic [T_W-1:0]   t_reg, t_next;
    logic [WORK_W-1:0] prev_x_reg, prev_x_next;
    logic [WORK_W-1:0] prev_y_reg, prev_y_next;
    logic [NP_W-1:0]  np_reg;

    logic [PIX_W-1:0]  ctrl_x_reg [MAX_POINTS];
    logic [PIX_W-1:0]  ctrl_y_reg [MAX_POINTS];
    logic [WORK_W-1:0] work_x_reg [MAX_POINTS];
    logic [WORK_W-1:0] work_y_reg [MAX_POINTS];

    logic                     s2_valid_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic [WORK_W-1:0]        s2_a_x_reg, s2_a_y_reg;
    logic signed [PROD_W-1:0] s2_prod_x_reg, s2_prod_y_reg;

    logic             done_reg, done_next;
    logic [PIX_W-1:0] curve_x_reg, curve_x_next;
    logic [PIX_W-1:0] curve_y_reg, curve_y_next;

    logic              accept;
    logic              ctrl_we;
    logic              issue;
    logic [CNT_W-1:0]  count;
    logic [T_W-1:0]    t_sat;
    logic [WORK_W-1:0] rd_x, rd_y;
    logic signed [T_W:0]      t_s;
    logic signed [DIFF_W-1:0] diff_x, diff_y;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic signed [PROD_W-1:0] rnd_x, rnd_y, sum_x, sum_y;

    assign accept  = start && (state_reg == ST_IDLE);
    assign ctrl_we = accept && (func == FUNC_WRITE) && (32'(point_index) < MAX_POINTS);
    assign busy    = (state_reg != ST_IDLE);

    always_comb
    begin
        if (np_reg == '0)
            count = CNT_W'(1);
        else if (CMP_W'(np_reg) > CMP_W'(MAX_POINTS))
            count = CNT_W'(MAX_POINTS);
        else
            count = CNT_W'(np_reg);
    end

    assign t_sat = (t_value > T_ONE) ? T_ONE : t_value;

    // first level streams straight from the point table
    assign rd_x = first_reg ? {ctrl_x_reg[rd_idx_reg], {COORD_FRAC{1'b0}}}
                            : work_x_reg[rd_idx_reg];
    assign rd_y = first_reg ? {ctrl_y_reg[rd_idx_reg], {COORD_FRAC{1'b0}}}
                            : work_y_reg[rd_idx_reg];

    // lerp(a, b) = a + ((t * (b - a) + half) >>> frac)
    assign t_s    = {1'b0, t_reg};
    assign diff_x = DIFF_W'(rd_x) - DIFF_W'(prev_x_reg);
    assign diff_y = DIFF_W'(rd_y) - DIFF_W'(prev_y_reg);
    assign prod_x = t_s * diff_x;
    assign prod_y = t_s * diff_y;

    assign rnd_x = (s2_prod_x_reg + PROD_W'(T_HALF)) >>> T_FRAC_BITS;
    assign rnd_y = (s2_prod_y_reg + PROD_W'(T_HALF)) >>> T_FRAC_BITS;
    assign sum_x = PROD_W'($signed({1'b0, s2_a_x_reg})) + rnd_x;
    assign sum_y = PROD_W'($signed({1'b0, s2_a_y_reg})) + rnd_y;

    always_comb
    begin
        state_next   = state_reg;
        level_next   = level_reg;
        rd_idx_next  = rd_idx_reg;
        first_next   = first_reg;
        single_next  = single_reg;
        t_next       = t_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        done_next    = 1'b0;
        curve_x_next = curve_x_reg;
        curve_y_next = curve_y_reg;
        issue        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_EVAL))
                begin
                    t_next      = t_sat;
                    first_next  = 1'b1;
                    rd_idx_next = '0;
                    level_next  = count;
                    single_next = (count == CNT_W'(1));
                    state_next  = (count == CNT_W'(1)) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                // element 0 of a level only primes prev
                issue       = (rd_idx_reg != '0);
                prev_x_next = rd_x;
                prev_y_next = rd_y;
                if (CNT_W'(rd_idx_reg) == level_reg - CNT_W'(1))
                begin
                    rd_idx_next = '0;
                    level_next  = level_reg - CNT_W'(1);
                    first_next  = 1'b0;
                    if (level_reg == CNT_W'(2))
                        state_next = ST_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                done_next    = 1'b1;
                curve_x_next = single_reg ? ctrl_x_reg[0] : round_pix(work_x_reg[0]);
                curve_y_next = single_reg ? ctrl_y_reg[0] : round_pix(work_y_reg[0]);
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            level_reg    <= '0;
            rd_idx_reg   <= '0;
            first_reg    <= 1'b0;
            single_reg   <= 1'b0;
            np_reg       <= NP_W'(1);
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            rd_idx_reg   <= rd_idx_next;
            first_reg    <= first_next;
            single_reg   <= single_next;
            s2_valid_reg <= issue;
            done_reg     <= done_next;
            if (cfg_we)
                np_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        prev_x_reg    <= prev_x_next;
        prev_y_reg    <= prev_y_next;
        curve_x_reg   <= curve_x_next;
        curve_y_reg   <= curve_y_next;
        s2_idx_reg    <= rd_idx_reg - IDX_W'(1);
        s2_a_x_reg    <= prev_x_reg;
        s2_a_y_reg    <= prev_y_reg;
        s2_prod_x_reg <= prod_x;
        s2_prod_y_reg <= prod_y;
        if (ctrl_we)
        begin
            ctrl_x_reg[IDX_W'(point_index)] <= point_x;
            ctrl_y_reg[IDX_W'(point_index)] <= point_y;
        end
        if (s2_valid_reg)
        begin
            work_x_reg[s2_idx_reg] <= sum_x[WORK_W-1:0];
            work_y_reg[s2_idx_reg] <= sum_y[WORK_W-1:0];
        end
    end

    assign done    = done_reg;
    assign curve_x = curve_x_reg;
    assign curve_y = curve_y_reg;

`ifndef SYNTHESIS
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("done without a finish cycle");

    a_lerp_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("lerp result pending outside run/drain");

    a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (CNT_W'(rd_idx_reg) < level_reg && level_reg >= CNT_W'(2)))
        else $error("read index or level out of range");

    a_single_point: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_EVAL && count == CNT_W'(1)) |=> (state_reg == ST_FINISH))
        else $error("single point evaluation not short-cut");
`endif

endmodule

[bench/bpe_curve_checker.sv]
module bpe_curve_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         func,
    input  logic [bpe_pkg::IDX_IN_W-1:0] point_index,
    input  logic [bpe_pkg::PIX_W-1:0]    point_x,
    input  logic [bpe_pkg::PIX_W-1:0]    point_y,
    input  logic [bpe_pkg::T_W-1:0]      t_value,
    input  logic                         done,
    input  logic [bpe_pkg::PIX_W-1:0]    curve_x,
    input  logic [bpe_pkg::PIX_W-1:0]    curve_y,
    input  logic                         cfg_we,
    input  logic [bpe_pkg::NP_W-1:0]     cfg_data,
    output int                           fail_count,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bpe_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
    } curve_pt_t;

    logic [PIX_W-1:0] ctrl_x [MAX_POINTS];
    logic [PIX_W-1:0] ctrl_y [MAX_POINTS];
    logic [NP_W-1:0]  np_reg;
    curve_pt_t        curve_q [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // de Casteljau on one coordinate lane, Q11.16 working values
    function automatic logic [PIX_W-1:0] eval_coord(input bit y_lane,
                                                    input logic [NP_W-1:0] np,
                                                    input logic [T_W-1:0] t_in);
        logic [63:0] lvl [MAX_POINTS];
        logic [63:0] t;
        logic [63:0] one_q;
        logic [63:0] rounded;
        int          count;
        one_q = 64'd1 << T_FRAC_BITS;
        t = 64'(t_in);
        if (t > one_q)
            t = one_q;
        count = int'(np);
        if (count < 1)
            count = 1;
        if (count > MAX_POINTS)
            count = MAX_POINTS;
        for (int i = 0; i < count; i++)
            lvl[i] = 64'(y_lane ? ctrl_y[i] : ctrl_x[i]) << COORD_FRAC;
        for (int k = count; k > 1; k--)
            for (int i = 0; i + 1 < k; i++)
                lvl[i] = ((one_q - t) * lvl[i] + t * lvl[i + 1] + (one_q >> 1)) >> T_FRAC_BITS;
        rounded = (lvl[0] + (64'd1 << (COORD_FRAC - 1))) >> COORD_FRAC;
        return rounded[PIX_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        curve_pt_t want;
        if (!rst_n)
        begin
            np_reg = NP_W'(1);
            curve_q.delete();
            pending <= 0;
        end
        else
        begin
            // results first: nothing accepted at this edge can answer at it
            if (done)
            begin
                if (curve_q.size() == 0)
                    report_mismatch($sformatf("result (%0d,%0d) with no request waiting",
                                              curve_x, curve_y));
                else
                begin
                    want = curve_q.pop_front();
                    if (curve_x !== want.x)
                        report_mismatch($sformatf("curve_x got %0d want %0d", curve_x, want.x));
                    if (curve_y !== want.y)
                        report_mismatch($sformatf("curve_y got %0d want %0d", curve_y, want.y));
                end
            end
            if (start && !busy)
            begin
                if (func == FUNC_WRITE)
                begin
                    ctrl_x[point_index] = point_x;
                    ctrl_y[point_index] = point_y;
                end
                else
                begin
                    want.x = eval_coord(1'b0, np_reg, t_value);
                    want.y = eval_coord(1'b1, np_reg, t_value);
                    curve_q.insert(curve_q.size(), want);
                end
            end
            // a request taken at this edge still sees the old count
            if (cfg_we)
                np_reg = cfg_data;
            pending <= curve_q.size();
        end
    end

endmodule

[bench/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpe_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                func = FUNC_WRITE;
    logic [IDX_IN_W-1:0] point_index = '0;
    logic [PIX_W-1:0]    point_x = '0;
    logic [PIX_W-1:0]    point_y = '0;
    logic [T_W-1:0]      t_value = '0;
    logic                cfg_we = 1'b0;
    logic [NP_W-1:0]     cfg_data = '0;
    logic                busy;
    logic                done;
    logic [PIX_W-1:0]    curve_x;
    logic [PIX_W-1:0]    curve_y;
    int                  fail_count;
    int                  pending;
    bit                  no_gaps = 1'b0;

    always #5 clk = ~clk;

    bezier_point_evaluator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .t_value     (t_value),
        .done        (done),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    bpe_curve_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .t_value     (t_value),
        .done        (done),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // start stays high after acceptance; the caller lowers it only for a gap or a drain
    task automatic send_request(input logic f, input logic [IDX_IN_W-1:0] idx,
                                input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                                input logic [T_W-1:0] t);
        start       <= 1'b1;
        func        <= f;
        point_index <= idx;
        point_x     <= px;
        point_y     <= py;
        t_value     <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_gap();
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 60);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_points(input logic [NP_W-1:0] n);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] rand_pix();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return '1;
        return PIX_W'($urandom_range(0, 2047));
    endfunction

    task automatic random_request();
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [T_W-1:0]   t;
        int unsigned      roll;
        px = rand_pix();
        py = rand_pix();
        roll = $urandom_range(0, 99);
        if (roll < 10)
            t = '0;
        else if (roll < 20)
            t = T_ONE;
        else if (roll < 30)
            t = T_W'($urandom_range(int'(T_ONE) + 1, (1 << T_W) - 1));
        else
            t = T_W'($urandom_range(0, int'(T_ONE) - 1));
        if ($urandom_range(0, 99) < 30)
            send_request(FUNC_WRITE, IDX_IN_W'($urandom_range(0, MAX_POINTS - 1)), px, py, t);
        else
            send_request(FUNC_EVAL, IDX_IN_W'($urandom_range(0, MAX_POINTS - 1)), px, py, t);
        idle_gap();
    endtask

    initial
    begin
        int np_sel;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table first so no evaluation reads an empty slot
        send_request(FUNC_WRITE, IDX_IN_W'(0), 11'h7FF, 11'h000, '0);
        send_request(FUNC_WRITE, IDX_IN_W'(1), 11'h000, 11'h7FF, '0);
        send_request(FUNC_WRITE, IDX_IN_W'(2), 11'h555, 11'h2AA, '0);
        send_request(FUNC_WRITE, IDX_IN_W'(3), 11'h2AA, 11'h555, '0);
        for (int s = 4; s < MAX_POINTS; s++)
            send_request(FUNC_WRITE, IDX_IN_W'(s), PIX_W'($urandom_range(0, 2047)),
                         PIX_W'($urandom_range(0, 2047)), '0);

        // single point returns itself at both ends of t
        send_request(FUNC_EVAL, '0, '0, '0, '0);
        send_request(FUNC_EVAL, '0, '0, '0, T_ONE);
        // point count zero acts as one; t here is driven above one
        set_points('0);
        send_request(FUNC_EVAL, '0, '0, '0, '1);
        set_points(NP_W'(2));
        send_request(FUNC_EVAL, '0, '0, '0, '0);
        send_request(FUNC_EVAL, '0, '0, '0, T_W'(T_HALF));
        send_request(FUNC_EVAL, '0, '0, '0, T_ONE);
        // count above table size saturates
        set_points(NP_W'(31));
        send_request(FUNC_EVAL, '0, '0, '0, T_W'(1));
        send_request(FUNC_EVAL, '0, '0, '0, T_ONE - T_W'(1));

        for (int ph = 0; ph < 15; ph++)
        begin
            if (ph == 0)
                np_sel = MAX_POINTS;
            else if (ph == 1)
                np_sel = MAX_POINTS + 1;
            else if (ph == 2)
                np_sel = 1;
            else if ($urandom_range(0, 3) == 0)
                np_sel = int'($urandom_range(0, 31));
            else
                np_sel = int'($urandom_range(2, 5));
            set_points(NP_W'(np_sel));
            no_gaps = (ph % 4 == 3);
            for (int n = 0; n < 89; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                random_request();
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
